// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/core/acc_alu_pkg.sv =====
// ============================================================================
// acc_alu_pkg
// Widths, opcodes, status codes, shared types and helper functions of the
// accumulator ALU.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package acc_alu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int OPC_W      = 4;
    localparam int OPND_W     = 48;
    localparam int ACC_W      = 32;
    localparam int ST_W       = 2;
    localparam int PROD_W     = ACC_W + OPND_W;
    localparam int ITER_STEPS = ACC_W;
    localparam int CNT_W      = $clog2(ITER_STEPS);
    localparam int SH_W       = $clog2(ACC_W);

    typedef logic [ACC_W-1:0]  acc_t;
    typedef logic [OPND_W-1:0] opmag_t;
    typedef logic [OPC_W-1:0]  opc_t;
    typedef logic [ST_W-1:0]   st_t;

    localparam opc_t OP_ADD  = 4'd0;
    localparam opc_t OP_SUB  = 4'd1;
    localparam opc_t OP_MUL  = 4'd2;
    localparam opc_t OP_DIV  = 4'd3;
    localparam opc_t OP_REM  = 4'd4;
    localparam opc_t OP_AND  = 4'd5;
    localparam opc_t OP_OR   = 4'd6;
    localparam opc_t OP_XOR  = 4'd7;
    localparam opc_t OP_SHL  = 4'd8;
    localparam opc_t OP_SHR  = 4'd9;
    localparam opc_t OP_LOAD = 4'd10;

    localparam st_t ST_OK     = 2'd0;
    localparam st_t ST_DIV0   = 2'd1;
    localparam st_t ST_SHIFT  = 2'd2;
    localparam st_t ST_OPCODE = 2'd3;

    localparam acc_t NEG_LIM = acc_t'(1) << (ACC_W - 1);
    localparam acc_t POS_LIM = ~NEG_LIM;

    // Control from the sequencer to the iterative unit
    typedef struct packed {
        logic start;
        logic div;
    } iter_ctrl_t;

    // Status from the iterative unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

    function automatic acc_t negate_if(input acc_t v, input logic neg);
        return neg ? (acc_t'(0) - v) : v;
    endfunction

    // Clamp a magnitude with sign into the signed accumulator range.
    function automatic acc_t sat_mag(input logic [PROD_W-1:0] mag, input logic neg);
        logic [PROD_W-1:0] lim;
        acc_t              m;
        lim = neg ? PROD_W'(NEG_LIM) : PROD_W'(POS_LIM);
        m   = (mag > lim) ? lim[ACC_W-1:0] : mag[ACC_W-1:0];
        return negate_if(m, neg);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acc_alu_if.sv =====
// ============================================================================
// acc_alu interfaces
// Valid/ready channels for the command and the result of the accumulator ALU.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface acc_alu_req_if;
    import acc_alu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic signed [OPND_W-1:0] operand;

    modport source (output valid, output opcode, output operand, input ready);
    modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface acc_alu_rsp_if;
    import acc_alu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] accumulator_out;
    logic [ST_W-1:0]         status;

    modport source (output valid, output accumulator_out, output status, input ready);
    modport sink   (input valid, input accumulator_out, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/acc_alu_opnd.sv =====
// ============================================================================
// acc_alu_opnd
// Splits the fixed-point operand into sign and magnitude and derives its
// integer part, truncated toward zero and saturated to the accumulator range.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module acc_alu_opnd (
    input  logic signed [acc_alu_pkg::OPND_W-1:0] operand,
    output logic                                  opneg,
    output acc_alu_pkg::opmag_t                   opmag,
    output acc_alu_pkg::acc_t                     int_val
);
    import acc_alu_pkg::*;

    assign opneg   = operand[OPND_W-1];
    // Most negative operand maps onto its own unsigned magnitude
    assign opmag   = opneg ? (opmag_t'(~operand) + opmag_t'(1)) : opmag_t'(operand);
    assign int_val = sat_mag(PROD_W'(opmag >> FRAC_BITS), opneg);

endmodule

`default_nettype wire

// ===== rtl/core/acc_alu_iter.sv =====
// ============================================================================
// acc_alu_iter
// Shared iterative unit: one adder runs either a shift-add multiply of a
// 32-bit magnitude by a 48-bit magnitude or a restoring 32-bit divide, one
// bit per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module acc_alu_iter (
    input  logic                     clk,
    input  logic                     rst_n,
    input  acc_alu_pkg::iter_ctrl_t  ctrl,
    input  acc_alu_pkg::acc_t        a_mag,
    input  acc_alu_pkg::opmag_t      b_mag,
    output acc_alu_pkg::iter_stat_t  stat,
    output acc_alu_pkg::opmag_t      hi,
    output acc_alu_pkg::acc_t        lo
);
    import acc_alu_pkg::*;

    logic             busy_reg, busy_next;
    logic             div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    opmag_t           hi_reg, hi_next;
    acc_t             lo_reg, lo_next;
    opmag_t           b_reg, b_next;

    logic [ACC_W:0]    tpart;
    logic [OPND_W:0]   add_a, add_b;
    logic              add_sub;
    logic [OPND_W+1:0] add_full;
    logic              ge;
    logic              last;

    // Partial remainder shifted left with the next dividend bit
    assign tpart = {hi_reg[ACC_W-1:0], lo_reg[ACC_W-1]};

    always_comb
    begin
        if (div_reg)
        begin
            add_a   = (OPND_W+1)'(tpart);
            add_b   = (OPND_W+1)'(b_reg);
            add_sub = 1'b1;
        end
        else
        begin
            add_a   = {1'b0, hi_reg};
            add_b   = lo_reg[0] ? {1'b0, b_reg} : '0;
            add_sub = 1'b0;
        end
        add_full = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                 + (OPND_W+2)'(add_sub);
    end

    // Carry out of the subtract means no borrow
    assign ge   = add_full[OPND_W+1];
    assign last = (cnt_reg == CNT_W'(ITER_STEPS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            div_next  = ctrl.div;
            cnt_next  = '0;
            hi_next   = '0;
            lo_next   = a_mag;
            b_next    = b_mag;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
            if (div_reg)
            begin
                hi_next = OPND_W'(ge ? add_full[ACC_W-1:0] : tpart[ACC_W-1:0]);
                lo_next = {lo_reg[ACC_W-2:0], ge};
            end
            else
            begin
                hi_next = add_full[OPND_W:1];
                lo_next = {add_full[0], lo_reg[ACC_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        b_reg   <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last;
    assign hi        = hi_reg;
    assign lo        = lo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/accumulator_alu_core.sv =====
// ============================================================================
// accumulator_alu_core
// 32-bit signed accumulator updated by one opcode per command transaction,
// with multiply and divide run on a shared bit-serial unit.
// ============================================================================
//
//   channel | dir | payload                    | handshake
//   --------+-----+----------------------------+-------------
//   req     | in  | opcode[3:0], operand[47:0] | valid/ready
//   rsp     | out | accumulator_out[31:0],     | valid/ready
//           |     | status[1:0]                |
//
// Add, sub, logic, shift, load and errors pass through the idle, execute and
// finish states; multiply, divide and remainder also pass through the iterate
// state, one bit per cycle on the shared add/subtract unit.
// req.ready is high only while the sequencer is idle; a result waiting in the
// rsp register does not block the next command until it must be replaced.
// Reset clears the accumulator to zero and empties the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module accumulator_alu_core (
    input  logic           clk,
    input  logic           rst_n,
    acc_alu_req_if.sink    req,
    acc_alu_rsp_if.source  rsp
);
    import acc_alu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_ITER = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    acc_t   acc_reg, acc_next;
    logic   rsp_valid_reg, rsp_valid_next;

    opc_t   opc_reg, opc_next;
    logic signed [OPND_W-1:0] opnd_reg, opnd_next;
    acc_t   res_reg, res_next;
    st_t    st_reg, st_next;
    logic   unit_reg, unit_next;
    logic   udiv_reg, udiv_next;
    logic   rem_reg, rem_next;
    logic   qneg_reg, qneg_next;
    acc_t   rsp_acc_reg, rsp_acc_next;
    st_t    rsp_st_reg, rsp_st_next;

    logic   opneg;
    opmag_t opmag;
    acc_t   int_val;

    logic       aneg, bneg;
    acc_t       am, bm;
    logic [SH_W-1:0] sh_amt;
    acc_t       exec_res;
    st_t        exec_st;
    logic       exec_unit, exec_div, exec_neg;
    opmag_t     exec_b;

    iter_ctrl_t ctrl;
    iter_stat_t stat;
    opmag_t     u_hi;
    acc_t       u_lo;

    logic [PROD_W-1:0] prod;
    acc_t       mul_res, div_res, fin_res;
    logic       fin_load;

    acc_alu_opnd u_opnd (
        .operand (opnd_reg),
        .opneg   (opneg),
        .opmag   (opmag),
        .int_val (int_val)
    );

    acc_alu_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .a_mag (am),
        .b_mag (exec_b),
        .stat  (stat),
        .hi    (u_hi),
        .lo    (u_lo)
    );

    assign aneg   = acc_reg[ACC_W-1];
    assign bneg   = int_val[ACC_W-1];
    assign am     = negate_if(acc_reg, aneg);
    assign bm     = negate_if(int_val, bneg);
    assign sh_amt = int_val[SH_W-1:0];

    // Combinational opcodes and error checks; multiply and divide go to the unit
    always_comb
    begin
        exec_res  = acc_reg;
        exec_st   = ST_OK;
        exec_unit = 1'b0;
        exec_div  = 1'b0;
        exec_b    = opmag;
        exec_neg  = aneg ^ opneg;
        unique case (opc_reg)
            OP_ADD:  exec_res = acc_reg + int_val;
            OP_SUB:  exec_res = acc_reg - int_val;
            OP_MUL:  exec_unit = 1'b1;
            OP_DIV, OP_REM:
            begin
                if (int_val == '0)
                begin
                    exec_st = ST_DIV0;
                end
                else
                begin
                    exec_unit = 1'b1;
                    exec_div  = 1'b1;
                    exec_b    = OPND_W'(bm);
                    // quotient sign from both, remainder sign from dividend
                    exec_neg  = (opc_reg == OP_DIV) ? (aneg ^ bneg) : aneg;
                end
            end
            OP_AND:  exec_res = acc_reg & int_val;
            OP_OR:   exec_res = acc_reg | int_val;
            OP_XOR:  exec_res = acc_reg ^ int_val;
            OP_SHL, OP_SHR:
            begin
                if (int_val > acc_t'(ACC_W - 1))
                begin
                    exec_st = ST_SHIFT;
                end
                else if (opc_reg == OP_SHL)
                begin
                    exec_res = acc_reg << sh_amt;
                end
                else
                begin
                    exec_res = acc_t'($signed(acc_reg) >>> sh_amt);
                end
            end
            OP_LOAD: exec_res = int_val;
            default: exec_st = ST_OPCODE;
        endcase
    end

    assign ctrl.start = (state_reg == S_EXEC) && exec_unit;
    assign ctrl.div   = exec_div;

    // Finish multiply and divide from the unit's registers, or pass the execute result
    assign prod    = {u_hi, u_lo};
    assign mul_res = sat_mag(prod >> FRAC_BITS, qneg_reg);
    assign div_res = negate_if(rem_reg ? u_hi[ACC_W-1:0] : u_lo, qneg_reg);
    assign fin_res = !unit_reg ? res_reg : (udiv_reg ? div_res : mul_res);

    assign fin_load = (state_reg == S_FIN) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        opc_next       = opc_reg;
        opnd_next      = opnd_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        unit_next      = unit_reg;
        udiv_next      = udiv_reg;
        rem_next       = rem_reg;
        qneg_next      = qneg_reg;
        rsp_acc_next   = rsp_acc_reg;
        rsp_st_next    = rsp_st_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    opc_next   = req.opcode;
                    opnd_next  = req.operand;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = exec_res;
                st_next    = exec_st;
                unit_next  = exec_unit;
                udiv_next  = exec_div;
                rem_next   = (opc_reg == OP_REM);
                qneg_next  = exec_neg;
                state_next = exec_unit ? S_ITER : S_FIN;
            end
            S_ITER:
            begin
                if (stat.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the result register is free
                if (fin_load)
                begin
                    acc_next       = fin_res;
                    rsp_acc_next   = fin_res;
                    rsp_st_next    = st_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opc_reg     <= opc_next;
        opnd_reg    <= opnd_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        unit_reg    <= unit_next;
        udiv_reg    <= udiv_next;
        rem_reg     <= rem_next;
        qneg_reg    <= qneg_next;
        rsp_acc_reg <= rsp_acc_next;
        rsp_st_reg  <= rsp_st_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.accumulator_out = rsp_acc_reg;
    assign rsp.status          = rsp_st_reg;

endmodule

`default_nettype wire

// ===== rtl/core/acc_alu_chk.sv =====
// ============================================================================
// acc_alu_chk
// Port-level checks of the accumulator ALU, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module acc_alu_chk (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    input  logic                                  req_ready,
    input  logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    input  logic signed [acc_alu_pkg::ACC_W-1:0]  accumulator_out,
    input  logic [acc_alu_pkg::ST_W-1:0]          status
);
    import acc_alu_pkg::*;

    // A command keeps req.ready low through the execute state and the state after it
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, req_valid && req_ready |=> !req_ready ##1 !req_ready, "req.ready high too soon after a command")

    // A new result is only posted from the finishing state, never from idle
    `ASSERT_NEVER(a_result_from_busy, clk, rst_n, $rose(rsp_valid) && $past(req_ready), "result appeared while the sequencer was idle")

    // A stalled result holds its payload
    `ASSERT_CLK(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(accumulator_out) && $stable(status), "stalled result changed")

endmodule

bind accumulator_alu_core acc_alu_chk u_acc_alu_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .accumulator_out (rsp.accumulator_out),
    .status          (rsp.status)
);

`default_nettype wire
